/* sv/ltd_pkg.sv */
// Shared types and constants for the lexer token scanner.
`default_nettype none
package ltd_pkg;

  localparam int CLS_W = 4;
  localparam int STATE_W = 4;
  localparam int TOKEN_W = 4;
  localparam int COUNT_W = 9;
  localparam int POS_W = 16;
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  localparam logic OP_FEED = 1'b0;
  localparam logic OP_RESTART = 1'b1;

  localparam logic [CLS_W-1:0] C_LETTER = 4'd0;
  localparam logic [CLS_W-1:0] C_DIGIT = 4'd1;
  localparam logic [CLS_W-1:0] C_BLANK = 4'd2;
  localparam logic [CLS_W-1:0] C_NL = 4'd3;
  localparam logic [CLS_W-1:0] C_SIGN = 4'd4;
  localparam logic [CLS_W-1:0] C_STAR = 4'd5;
  localparam logic [CLS_W-1:0] C_COLON = 4'd6;
  localparam logic [CLS_W-1:0] C_EQUAL = 4'd7;
  localparam logic [CLS_W-1:0] C_AMP = 4'd8;
  localparam logic [CLS_W-1:0] C_OTHER = 4'd9;

  localparam logic [STATE_W-1:0] S_START = 4'd0;
  localparam logic [STATE_W-1:0] S_IDENT = 4'd1;
  localparam logic [STATE_W-1:0] S_SPACE = 4'd2;
  localparam logic [STATE_W-1:0] S_INT = 4'd3;
  localparam logic [STATE_W-1:0] S_SIGN = 4'd4;
  localparam logic [STATE_W-1:0] S_COLON = 4'd5;
  localparam logic [STATE_W-1:0] S_EQUAL = 4'd6;
  localparam logic [STATE_W-1:0] S_EQCOL = 4'd7;
  localparam logic [STATE_W-1:0] S_CMT1 = 4'd8;
  localparam logic [STATE_W-1:0] S_CMT2 = 4'd9;
  localparam logic [STATE_W-1:0] S_CMT3 = 4'd10;
  localparam logic [STATE_W-1:0] S_AND = 4'd11;

  localparam logic [TOKEN_W-1:0] T_SPACE = 4'd0;
  localparam logic [TOKEN_W-1:0] T_IDENT = 4'd1;
  localparam logic [TOKEN_W-1:0] T_NEWLINE = 4'd2;
  localparam logic [TOKEN_W-1:0] T_INT = 4'd3;
  localparam logic [TOKEN_W-1:0] T_SIGN = 4'd4;
  localparam logic [TOKEN_W-1:0] T_COLON = 4'd5;
  localparam logic [TOKEN_W-1:0] T_EQUAL = 4'd6;
  localparam logic [TOKEN_W-1:0] T_EQASSIGN = 4'd7;
  localparam logic [TOKEN_W-1:0] T_COMMENT = 4'd8;
  localparam logic [TOKEN_W-1:0] T_DAND = 4'd9;
  localparam logic [TOKEN_W-1:0] T_ASSIGN = 4'd10;
  localparam logic [TOKEN_W-1:0] T_UNKNOWN = 4'd11;

  localparam logic signed [COUNT_W-1:0] COUNT_MAX = 9'sd255;
  localparam logic signed [COUNT_W-1:0] COUNT_NEG = -9'sd1;
  localparam logic signed [COUNT_W-1:0] COUNT_ONE = 9'sd1;
  localparam logic [POS_W-1:0] POS_RESET = 16'd1;

  typedef struct packed {
    logic op;
    logic [CLS_W-1:0] cls;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] col;
  } ltd_item_t;

endpackage
`default_nettype wire

/* sv/ltd_front.sv */
// Front end: classifies each incoming character into a scanner class.
`default_nettype none
module ltd_front (
  input  wire logic                   op,
  input  wire logic [7:0]             ch,
  input  wire logic [15:0]            start_line,
  input  wire logic [15:0]            start_col,
  output ltd_pkg::ltd_item_t          item
);
  import ltd_pkg::*;

  logic [CLS_W-1:0] cls;

  always_comb begin
    if ((ch >= 8'h61 && ch <= 8'h7a) || (ch >= 8'h41 && ch <= 8'h5a)) begin
      cls = C_LETTER;
    end else if (ch >= 8'h30 && ch <= 8'h39) begin
      cls = C_DIGIT;
    end else begin
      case (ch)
        8'h20, 8'h09: cls = C_BLANK;
        8'h0a, 8'h0d: cls = C_NL;
        8'h2a: cls = C_STAR;
        8'h3a: cls = C_COLON;
        8'h3d: cls = C_EQUAL;
        8'h26: cls = C_AMP;
        8'h2b, 8'h2d, 8'h3c, 8'h3e, 8'h21, 8'h3b, 8'h28, 8'h29,
        8'h7b, 8'h7d, 8'h5b, 8'h5d: cls = C_SIGN;
        default: cls = C_OTHER;
      endcase
    end
  end

  assign item.op = op;
  assign item.cls = cls;
  assign item.line = start_line;
  assign item.col = start_col;

endmodule
`default_nettype wire

/* sv/ltd_queue.sv */
// Short queue of classified items between the front and back ends.
`default_nettype none
module ltd_queue (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               push_valid,
  output logic                    push_ready,
  input  ltd_pkg::ltd_item_t      push_item,
  output logic                    pop_valid,
  input  wire logic               pop_ready,
  output ltd_pkg::ltd_item_t      pop_item
);
  import ltd_pkg::*;

  ltd_item_t mem [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = (count != QCNT_W'(QDEPTH));
  assign pop_valid = (count != '0);
  assign pop_item = mem[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

/* sv/ltd_back.sv */
// Back end: scanner automaton state, transition logic and result register.
`default_nettype none
module ltd_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               item_valid,
  output logic                    item_ready,
  input  ltd_pkg::ltd_item_t      item,
  output logic                    res_valid,
  input  wire logic               res_ready,
  output logic                    res_more,
  output logic [3:0]              res_token_type,
  output logic signed [8:0]       res_back_count,
  output logic [15:0]             res_lexeme_line,
  output logic [15:0]             res_lexeme_col
);
  import ltd_pkg::*;

  logic [STATE_W-1:0] scan_state;
  logic [STATE_W-1:0] scan_state_next;
  logic [TOKEN_W-1:0] last_final;
  logic [TOKEN_W-1:0] last_final_next;
  logic signed [COUNT_W-1:0] put_back;
  logic signed [COUNT_W-1:0] put_back_next;
  logic signed [COUNT_W-1:0] bumped;
  logic [POS_W-1:0] lexeme_line_reg;
  logic [POS_W-1:0] lexeme_line_reg_next;
  logic [POS_W-1:0] lexeme_col_reg;
  logic [POS_W-1:0] lexeme_col_reg_next;
  logic more_next;
  logic take;

  assign item_ready = !res_valid || res_ready;
  assign take = item_valid && item_ready;
  assign bumped = (put_back < COUNT_MAX) ? put_back + COUNT_ONE : put_back;

  always_comb begin
    scan_state_next = scan_state;
    last_final_next = last_final;
    put_back_next = put_back;
    lexeme_line_reg_next = lexeme_line_reg;
    lexeme_col_reg_next = lexeme_col_reg;
    more_next = 1'b0;
    if (item.op == OP_RESTART) begin
      scan_state_next = S_START;
      last_final_next = T_UNKNOWN;
      put_back_next = '0;
      lexeme_line_reg_next = item.line;
      lexeme_col_reg_next = item.col;
      more_next = 1'b1;
    end else begin
      case (scan_state)
        S_START: begin
          put_back_next = '0;
          case (item.cls)
            C_LETTER: begin
              scan_state_next = S_IDENT;
              last_final_next = T_IDENT;
              more_next = 1'b1;
            end
            C_BLANK: begin
              scan_state_next = S_SPACE;
              last_final_next = T_SPACE;
              more_next = 1'b1;
            end
            C_DIGIT: begin
              scan_state_next = S_INT;
              last_final_next = T_INT;
              more_next = 1'b1;
            end
            C_SIGN, C_STAR: begin
              scan_state_next = S_SIGN;
              last_final_next = T_SIGN;
            end
            C_COLON: begin
              scan_state_next = S_COLON;
              last_final_next = T_COLON;
              more_next = 1'b1;
            end
            C_EQUAL: begin
              scan_state_next = S_EQUAL;
              last_final_next = T_EQUAL;
              more_next = 1'b1;
            end
            C_AMP: begin
              scan_state_next = S_AND;
              put_back_next = bumped;
              more_next = 1'b1;
            end
            C_NL: begin
              last_final_next = T_NEWLINE;
            end
            default: begin
              last_final_next = T_UNKNOWN;
            end
          endcase
        end
        S_IDENT: begin
          if (item.cls == C_LETTER || item.cls == C_DIGIT) begin
            more_next = 1'b1;
          end else begin
            put_back_next = bumped;
          end
        end
        S_SPACE: begin
          if (item.cls == C_BLANK) begin
            more_next = 1'b1;
          end else begin
            put_back_next = bumped;
          end
        end
        S_INT: begin
          if (item.cls == C_DIGIT) begin
            more_next = 1'b1;
          end else begin
            put_back_next = bumped;
          end
        end
        S_COLON: begin
          if (item.cls == C_STAR) begin
            scan_state_next = S_CMT1;
            last_final_next = T_COMMENT;
            put_back_next = '0;
            more_next = 1'b1;
          end else if (item.cls == C_EQUAL) begin
            last_final_next = T_ASSIGN;
            put_back_next = '0;
          end else begin
            put_back_next = bumped;
          end
        end
        S_EQUAL: begin
          if (item.cls == C_COLON) begin
            scan_state_next = S_EQCOL;
            last_final_next = T_EQUAL;
            put_back_next = COUNT_ONE;
            more_next = 1'b1;
          end else begin
            put_back_next = bumped;
          end
        end
        S_EQCOL: begin
          if (item.cls == C_EQUAL) begin
            last_final_next = T_EQASSIGN;
            put_back_next = COUNT_NEG;
          end else begin
            put_back_next = bumped;
          end
        end
        S_CMT1: begin
          more_next = 1'b1;
          if (item.cls == C_STAR) begin
            scan_state_next = S_CMT2;
            last_final_next = T_COMMENT;
            put_back_next = '0;
          end
        end
        S_CMT2: begin
          more_next = 1'b1;
          if (item.cls == C_COLON) begin
            scan_state_next = S_CMT3;
            last_final_next = T_COMMENT;
            put_back_next = '0;
          end else if (item.cls != C_STAR) begin
            scan_state_next = S_CMT1;
            if (item.cls != C_NL) begin
              last_final_next = T_COMMENT;
              put_back_next = '0;
            end
          end
        end
        S_AND: begin
          if (item.cls == C_AMP) begin
            last_final_next = T_DAND;
            put_back_next = COUNT_NEG;
          end else begin
            put_back_next = bumped;
          end
        end
        default: begin
          put_back_next = bumped;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_state <= S_START;
      last_final <= T_UNKNOWN;
      put_back <= '0;
      lexeme_line_reg <= POS_RESET;
      lexeme_col_reg <= POS_RESET;
      res_valid <= 1'b0;
    end else begin
      if (take) begin
        scan_state <= scan_state_next;
        last_final <= last_final_next;
        put_back <= put_back_next;
        lexeme_line_reg <= lexeme_line_reg_next;
        lexeme_col_reg <= lexeme_col_reg_next;
        res_valid <= 1'b1;
      end else if (res_ready) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      res_more <= more_next;
      res_token_type <= last_final_next;
      res_back_count <= put_back_next;
      res_lexeme_line <= lexeme_line_reg_next;
      res_lexeme_col <= lexeme_col_reg_next;
    end
  end

endmodule
`default_nettype wire

/* sv/lexer_token_dfa.sv */
// Top level of the maximal-munch lexer scanner automaton.
// Each transaction on the input either feeds one character or restarts the scanner
// with the start line and column of the next lexeme, and yields exactly one result:
// whether more characters may extend the token, the type of the last final state,
// the signed count of characters to put back (saturating at 255, and -1 after the
// closing character of '&&' or '=:='), and the lexeme's start position. The block
// takes one item per clock cycle while in_ready is high; an accepted item is written
// into the queue and then, once the back end takes it, into the result register. The
// front end classifies the character, a two-entry queue decouples it from the back
// end, and the back end applies one automaton transition per cycle while its result
// register is empty or being taken, so both sides may stall independently.
`default_nettype none
module lexer_token_dfa (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic               op,
  input  wire logic [7:0]         ch,
  input  wire logic [15:0]        start_line,
  input  wire logic [15:0]        start_col,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic                    more,
  output logic [3:0]              token_type,
  output logic signed [8:0]       back_count,
  output logic [15:0]             lexeme_line,
  output logic [15:0]             lexeme_col
);
  import ltd_pkg::*;

  ltd_item_t front_item;
  ltd_item_t queue_item;
  logic queue_valid;
  logic queue_ready;

  ltd_front u_front (
    .op         (op),
    .ch         (ch),
    .start_line (start_line),
    .start_col  (start_col),
    .item       (front_item)
  );

  ltd_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (in_valid),
    .push_ready (in_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (queue_ready),
    .pop_item   (queue_item)
  );

  ltd_back u_back (
    .clk             (clk),
    .rst             (rst),
    .item_valid      (queue_valid),
    .item_ready      (queue_ready),
    .item            (queue_item),
    .res_valid       (out_valid),
    .res_ready       (out_ready),
    .res_more        (more),
    .res_token_type  (token_type),
    .res_back_count  (back_count),
    .res_lexeme_line (lexeme_line),
    .res_lexeme_col  (lexeme_col)
  );

endmodule
`default_nettype wire

/* dv/tb_lexer_token_dfa.sv */
// Self-checking testbench for the lexer token scanner automaton.
`timescale 1ns / 100ps

module tb_lexer_token_dfa;
  import ltd_pkg::*;

  localparam int STALL_LIMIT = 2000;
  localparam int TAIL_CYCLES = 8;
  localparam int RANDOM_ITEMS = 950;
  localparam logic [7:0] CH_TAB = 8'h09;
  localparam logic [7:0] CH_LF = 8'h0A;
  localparam logic [7:0] CH_CR = 8'h0D;

  typedef struct packed {
    logic more;
    logic [TOKEN_W-1:0] token_type;
    logic signed [COUNT_W-1:0] back_count;
    logic [POS_W-1:0] lexeme_line;
    logic [POS_W-1:0] lexeme_col;
  } lex_result_t;

  typedef enum int {
    K_IDENT, K_INT, K_BLANKS, K_NEWLINE, K_SIGN, K_COLON, K_ASSIGN, K_EQUAL,
    K_EQASSIGN, K_DAND, K_COMMENT, K_LONE_AMP, K_NOISE
  } lexeme_kind_e;

  class lex_scoreboard;
    lex_result_t token_q[$];
    int errors;
    logic [STATE_W-1:0] state;
    logic [TOKEN_W-1:0] last_tok;
    int back;
    logic [POS_W-1:0] line;
    logic [POS_W-1:0] col;

    function new();
      errors = 0;
      state = S_START;
      last_tok = T_UNKNOWN;
      back = 0;
      line = POS_RESET;
      col = POS_RESET;
    endfunction

    function void hit(logic [TOKEN_W-1:0] t);
      last_tok = t;
      back = 0;
    endfunction

    function void bump();
      if (back < 255) back++;
    endfunction

    function bit scan_char(logic [7:0] c);
      bit letter, digit, blank, nl;
      letter = (c >= "a" && c <= "z") || (c >= "A" && c <= "Z");
      digit = c >= "0" && c <= "9";
      blank = c == " " || c == CH_TAB;
      nl = c == CH_LF || c == CH_CR;
      case (state)
        S_START: begin
          if (letter) begin state = S_IDENT; hit(T_IDENT); return 1'b1; end
          if (blank) begin state = S_SPACE; hit(T_SPACE); return 1'b1; end
          if (digit) begin state = S_INT; hit(T_INT); return 1'b1; end
          if (c inside {"+", "-", "*", "<", ">", "!", ";", "(", ")", "{", "}", "[", "]"}) begin
            state = S_SIGN;
            hit(T_SIGN);
            return 1'b0;
          end
          if (c == ":") begin state = S_COLON; hit(T_COLON); return 1'b1; end
          if (c == "=") begin state = S_EQUAL; hit(T_EQUAL); return 1'b1; end
          if (c == "&") begin state = S_AND; bump(); return 1'b1; end
          if (nl) begin hit(T_NEWLINE); return 1'b0; end
          hit(T_UNKNOWN);
          return 1'b0;
        end
        S_IDENT: begin
          if (letter || digit) return 1'b1;
          bump();
          return 1'b0;
        end
        S_SPACE: begin
          if (blank) return 1'b1;
          bump();
          return 1'b0;
        end
        S_INT: begin
          if (digit) return 1'b1;
          bump();
          return 1'b0;
        end
        S_COLON: begin
          if (c == "*") begin state = S_CMT1; hit(T_COMMENT); return 1'b1; end
          if (c == "=") begin hit(T_ASSIGN); return 1'b0; end
          bump();
          return 1'b0;
        end
        S_EQUAL: begin
          if (c == ":") begin
            state = S_EQCOL;
            hit(T_EQUAL);
            bump();
            return 1'b1;
          end
          bump();
          return 1'b0;
        end
        S_EQCOL: begin
          if (c == "=") begin hit(T_EQASSIGN); back = -1; return 1'b0; end
          bump();
          return 1'b0;
        end
        S_CMT1: begin
          if (c == "*") begin state = S_CMT2; hit(T_COMMENT); end
          return 1'b1;
        end
        S_CMT2: begin
          if (c == ":") begin state = S_CMT3; hit(T_COMMENT); return 1'b1; end
          if (c == "*") return 1'b1;
          state = S_CMT1;
          if (!nl) hit(T_COMMENT);
          return 1'b1;
        end
        S_AND: begin
          if (c == "&") begin hit(T_DAND); back = -1; return 1'b0; end
          bump();
          return 1'b0;
        end
        default: begin
          bump();
          return 1'b0;
        end
      endcase
    endfunction

    function void note_input(logic o, logic [7:0] c, logic [POS_W-1:0] l,
                             logic [POS_W-1:0] cl);
      lex_result_t r;
      if (o == OP_RESTART) begin
        state = S_START;
        last_tok = T_UNKNOWN;
        back = 0;
        line = l;
        col = cl;
        r.more = 1'b1;
      end else begin
        r.more = scan_char(c);
      end
      r.token_type = last_tok;
      r.back_count = back[COUNT_W-1:0];
      r.lexeme_line = line;
      r.lexeme_col = col;
      token_q.push_back(r);
    endfunction

    function void field_check(string name, int want, int got);
      if (want != got) begin
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        errors++;
      end
    endfunction

    function void check_result(lex_result_t got);
      lex_result_t want;
      if (token_q.size() == 0) begin
        $display("%0t: result with no transaction pending, actual %p", $time, got);
        errors++;
        return;
      end
      want = token_q.pop_front();
      field_check("more", want.more, got.more);
      field_check("token_type", want.token_type, got.token_type);
      field_check("back_count", int'(want.back_count), int'(got.back_count));
      field_check("lexeme_line", want.lexeme_line, got.lexeme_line);
      field_check("lexeme_col", want.lexeme_col, got.lexeme_col);
    endfunction

    function int pending();
      return token_q.size();
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic op = OP_FEED;
  logic [7:0] ch = 8'd0;
  logic [POS_W-1:0] start_line = '0;
  logic [POS_W-1:0] start_col = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic more;
  logic [TOKEN_W-1:0] token_type;
  logic signed [COUNT_W-1:0] back_count;
  logic [POS_W-1:0] lexeme_line;
  logic [POS_W-1:0] lexeme_col;

  lex_scoreboard sb;
  lex_result_t seen;
  bit in_burst = 1'b0;
  bit out_burst = 1'b0;
  int out_hold = 0;
  int idle_cycles = 0;
  int items_sent = 0;
  string sign_set = "+-*<>!;(){}[]";
  string hot_set = "aZz09 :=&*+<![";

  lexer_token_dfa u_top (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .op(op),
    .ch(ch),
    .start_line(start_line),
    .start_col(start_col),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .more(more),
    .token_type(token_type),
    .back_count(back_count),
    .lexeme_line(lexeme_line),
    .lexeme_col(lexeme_col)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic int pick_gap(bit quiet);
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 25);
  endfunction

  function automatic logic [POS_W-1:0] pick_pos();
    int r;
    r = $urandom_range(0, 9);
    if (r < 2) return '0;
    if (r < 4) return '1;
    return POS_W'($urandom);
  endfunction

  function automatic logic [7:0] rand_letter();
    return $urandom_range(0, 1) ? 8'($urandom_range("a", "z")) : 8'($urandom_range("A", "Z"));
  endfunction

  function automatic logic [7:0] rand_byte();
    int r;
    r = $urandom_range(0, 9);
    if (r < 5) return 8'($urandom_range(0, 255));
    if (r == 5) return $urandom_range(0, 1) ? CH_LF : CH_CR;
    if (r == 6) return CH_TAB;
    return hot_set[$urandom_range(0, hot_set.len() - 1)];
  endfunction

  task automatic send_item(logic o, logic [7:0] c, logic [POS_W-1:0] l, logic [POS_W-1:0] cl);
    int gap;
    gap = pick_gap(in_burst);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    op <= o;
    ch <= c;
    start_line <= l;
    start_col <= cl;
    do @(posedge clk); while (!in_ready);
    sb.note_input(o, c, l, cl);
    items_sent++;
  endtask

  task automatic send_char(logic [7:0] c);
    send_item(OP_FEED, c, POS_W'($urandom), POS_W'($urandom));
  endtask

  task automatic restart(logic [POS_W-1:0] l, logic [POS_W-1:0] cl);
    send_item(OP_RESTART, 8'($urandom_range(0, 255)), l, cl);
  endtask

  task automatic send_lexeme();
    lexeme_kind_e kind;
    int n;
    if ($urandom_range(0, 9) == 0) in_burst = ~in_burst;
    if ($urandom_range(0, 6) != 0) restart(pick_pos(), pick_pos());
    kind = lexeme_kind_e'($urandom_range(0, K_NOISE));
    case (kind)
      K_IDENT: begin
        send_char(rand_letter());
        n = $urandom_range(0, 6);
        repeat (n) send_char($urandom_range(0, 1) ? rand_letter() : 8'($urandom_range("0", "9")));
      end
      K_INT: begin
        n = $urandom_range(1, 6);
        repeat (n) send_char(8'($urandom_range("0", "9")));
      end
      K_BLANKS: begin
        n = $urandom_range(1, 5);
        repeat (n) send_char($urandom_range(0, 1) ? CH_TAB : 8'(" "));
      end
      K_NEWLINE: send_char($urandom_range(0, 1) ? CH_LF : CH_CR);
      K_SIGN: send_char(sign_set[$urandom_range(0, sign_set.len() - 1)]);
      K_COLON: send_char(":");
      K_ASSIGN: begin send_char(":"); send_char("="); end
      K_EQUAL: send_char("=");
      K_EQASSIGN: begin send_char("="); send_char(":"); send_char("="); end
      K_DAND: begin send_char("&"); send_char("&"); end
      K_COMMENT: begin
        send_char(":");
        send_char("*");
        n = $urandom_range(0, 8);
        repeat (n) send_char($urandom_range(0, 2) == 0 ? 8'("*") : rand_byte());
        send_char("*");
        send_char(":");
      end
      K_LONE_AMP: send_char("&");
      default: begin
        n = $urandom_range(1, 8);
        repeat (n) send_char(8'($urandom_range(0, 255)));
      end
    endcase
    n = $urandom_range(0, 3);
    repeat (n) send_char(rand_byte());
    if ($urandom_range(0, 149) == 0) begin
      n = $urandom_range(256, 270);
      repeat (n) send_char(rand_byte());
    end
  endtask

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      seen = '{more, token_type, back_count, lexeme_line, lexeme_col};
      sb.check_result(seen);
    end
    if ($urandom_range(0, 63) == 0) out_burst = ~out_burst;
    if (out_hold != 0) begin
      out_ready <= 1'b0;
      out_hold <= out_hold - 1;
    end else begin
      out_ready <= 1'b1;
      out_hold <= pick_gap(out_burst);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_lexer_token_dfa NOT OK");
      $finish;
    end
  end

  initial begin
    sb = new();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Feeds before any restart see the reset position of one and one.
    send_char("a");
    send_char("9");
    send_char(" ");
    restart('0, '0);
    send_char(8'h00);
    send_char(CH_LF);
    send_char(CH_CR);
    send_char(8'hFF);
    restart('1, '1);
    send_char(CH_TAB);
    send_char(" ");
    send_char("Z");
    restart(16'h1234, 16'h8001);
    send_char("&");
    send_char("&");
    send_char("&");
    send_char("x");
    restart(16'h00FF, 16'hFF00);
    send_char("=");
    send_char(":");
    send_char("=");
    restart(16'h5555, 16'hAAAA);
    send_char(":");
    send_char("*");
    send_char("*");
    send_char(":");

    // A sign followed by a long run drives the put-back count into saturation.
    restart(pick_pos(), pick_pos());
    send_char("+");
    repeat (260) send_char(rand_byte());

    while (items_sent < RANDOM_ITEMS + 25) send_lexeme();
    in_valid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("tb_lexer_token_dfa OK");
    end else begin
      $display("tb_lexer_token_dfa NOT OK");
    end
    $finish;
  end

endmodule
